### rtl/sxb_pkg.sv
`timescale 1ns / 1ps

package sxb_pkg;

   localparam int DISPLAY_WIDTH_DEF  = 64;
   localparam int DISPLAY_HEIGHT_DEF = 32;

   localparam int KIND_BITS   = 2;
   localparam int COORD_BITS  = 8;
   localparam int OFFSET_BITS = 4;
   localparam int SPRITE_BITS = 8;
   localparam int ROW_BITS    = 64;

   // Item kinds.
   localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_DRAW  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_READ  = 2'd2;

   typedef logic [KIND_BITS-1:0] kind_type;

endpackage

### rtl/sprite_xor_blitter_unit.sv
`timescale 1ns / 1ps

// A result beat is registered when the item finishes, which needs the result register to be
// empty or draining; the row is read at the accepting edge and written back when the
// item finishes. A new item is not taken until the current one has finished. A result
// beat left waiting for rsp_ready holds the item, and req_ready stays low until it leaves.
// Reset clears the collision flag and every row valid bit, so the framebuffer reads as
// zero at once, with no clearing pass.
module sprite_xor_blitter_unit #(
   parameter int DISPLAY_WIDTH  = sxb_pkg::DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = sxb_pkg::DISPLAY_HEIGHT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sxb_pkg::KIND_BITS-1:0]      req_kind,
   input  logic [sxb_pkg::COORD_BITS-1:0]     req_x_coord,
   input  logic [sxb_pkg::COORD_BITS-1:0]     req_y_coord,
   input  logic [sxb_pkg::OFFSET_BITS-1:0]    req_row_offset,
   input  logic [sxb_pkg::SPRITE_BITS-1:0]    req_sprite_bits,
   input  logic                               req_first_row,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_collision,
   output logic [sxb_pkg::ROW_BITS-1:0]       rsp_row_pixels
);

   localparam int XW = $clog2(DISPLAY_WIDTH);
   localparam int AW = $clog2(DISPLAY_HEIGHT);
   localparam int RW = $clog2(DISPLAY_HEIGHT + 16);
   localparam int SW = DISPLAY_WIDTH + sxb_pkg::SPRITE_BITS;
   localparam int NCOORD = 1 << sxb_pkg::COORD_BITS;

   // Constant remainder tables for the 8-bit raw coordinates.
   logic [XW-1:0] xmod_lut [NCOORD];
   logic [AW-1:0] ymod_lut [NCOORD];

   for (genvar i = 0; i < NCOORD; i++) begin : g_mod
      assign xmod_lut[i] = XW'(i % DISPLAY_WIDTH);
      assign ymod_lut[i] = AW'(i % DISPLAY_HEIGHT);
   end

   logic [DISPLAY_WIDTH-1:0]  frame_mem [DISPLAY_HEIGHT];
   logic [DISPLAY_WIDTH-1:0]  rd_data_ff;
   logic                      rd_valid_ff;
   logic [DISPLAY_HEIGHT-1:0] row_valid_ff;

   logic                      busy_ff;
   sxb_pkg::kind_type         kind_ff;
   logic [XW-1:0]             xmod_ff;
   logic [AW-1:0]             addr_ff;
   logic                      draw_ok_ff;
   logic                      first_row_ff;
   logic [sxb_pkg::SPRITE_BITS-1:0] bits_ff;
   logic                      collision_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_collision_ff;
   logic [sxb_pkg::ROW_BITS-1:0] rsp_row_pixels_ff;

   logic                      req_fire;
   logic                      out_free;
   logic                      finish;
   logic [AW-1:0]             ymod;
   logic [RW-1:0]             target_row;
   logic                      target_ok;
   logic [AW-1:0]             rd_addr;

   logic [sxb_pkg::SPRITE_BITS-1:0] sprite_rev;
   logic [SW-1:0]             sprite_wide;
   logic [DISPLAY_WIDTH-1:0]  sprite_mask;
   logic [DISPLAY_WIDTH-1:0]  old_row;
   logic [DISPLAY_WIDTH-1:0]  new_row_in;
   logic                      hit;
   logic                      collision_in;
   logic                      do_write;
   logic                      do_clear;
   logic [sxb_pkg::ROW_BITS-1:0] pixels_in;

   assign req_ready = !busy_ff && !reset;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish    = busy_ff && out_free;

   assign ymod       = ymod_lut[req_y_coord];
   assign target_row = RW'(ymod) + RW'(req_row_offset);
   assign target_ok  = target_row < RW'(DISPLAY_HEIGHT);
   // Out-of-range draws still read a legal row; nothing is written back.
   assign rd_addr    = (req_kind == sxb_pkg::KIND_DRAW && target_ok) ?
                       target_row[AW-1:0] : ymod;

   // Read the addressed row at the accepting edge.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff  <= frame_mem[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
      if (do_write) begin
         frame_mem[addr_ff] <= new_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff      <= req_kind;
         xmod_ff      <= xmod_lut[req_x_coord];
         addr_ff      <= rd_addr;
         draw_ok_ff   <= target_ok;
         first_row_ff <= req_first_row;
         bits_ff      <= req_sprite_bits;
      end
   end

   // The sprite byte has its leftmost pixel in bit 7; rows have it in bit 0.
   always_comb begin
      for (int c = 0; c < sxb_pkg::SPRITE_BITS; c++) begin
         sprite_rev[c] = bits_ff[sxb_pkg::SPRITE_BITS-1-c];
      end
   end

   // Pixels shifted past the right edge fall into the discarded top bits.
   assign sprite_wide = SW'(sprite_rev) << xmod_ff;
   assign sprite_mask = sprite_wide[DISPLAY_WIDTH-1:0];
   assign old_row     = rd_valid_ff ? rd_data_ff : '0;
   assign new_row_in  = old_row ^ sprite_mask;
   assign hit         = |(old_row & sprite_mask);

   always_comb begin
      collision_in = collision_ff;
      do_write     = 1'b0;
      do_clear     = 1'b0;
      pixels_in    = '0;
      unique case (kind_ff)
         sxb_pkg::KIND_CLEAR: begin
            do_clear = finish;
         end
         sxb_pkg::KIND_DRAW: begin
            collision_in = (collision_ff && !first_row_ff) || (draw_ok_ff && hit);
            do_write     = finish && draw_ok_ff;
         end
         sxb_pkg::KIND_READ: begin
            pixels_in = sxb_pkg::ROW_BITS'(old_row);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         collision_ff <= 1'b0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            busy_ff <= 1'b1;
         end else if (finish) begin
            busy_ff <= 1'b0;
         end
         if (finish) begin
            collision_ff <= collision_in;
         end
         if (do_clear) begin
            row_valid_ff <= '0;
         end else if (do_write) begin
            row_valid_ff[addr_ff] <= 1'b1;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_collision_ff  <= collision_in;
         rsp_row_pixels_ff <= pixels_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_collision  = rsp_collision_ff;
   assign rsp_row_pixels = rsp_row_pixels_ff;

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> busy_ff)
      else $error("accepted beat did not start work");

   a_finish_result : assert property (@(posedge clock) disable iff (reset)
      finish |=> (!busy_ff && rsp_valid_ff))
      else $error("finished item did not produce a result beat");

   a_clear_rows : assert property (@(posedge clock) disable iff (reset)
      (finish && kind_ff == sxb_pkg::KIND_CLEAR) |=> (row_valid_ff == '0))
      else $error("clear did not drop all row valid bits");

   a_clip_rows : assert property (@(posedge clock) disable iff (reset)
      (finish && kind_ff == sxb_pkg::KIND_DRAW && !draw_ok_ff) |=> $stable(row_valid_ff))
      else $error("clipped row changed the framebuffer");

endmodule
